// ----- design/tknl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tknl_pkg
// Types and constants shared by the nearest-entry list and its cells.
// ----------------------------------------------------------------------------
package tknl_pkg;

   localparam int MAX_KEEP_DEFAULT = 16;
   localparam int LIMIT_W          = 5;
   localparam int DIST_W           = 32;
   localparam int ID_W             = 32;

   localparam logic [LIMIT_W-1:0] KEEP_LIMIT_RESET = 5'd16;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DRAIN  = 1'b1;

   typedef struct packed {
      logic              operation;
      logic [DIST_W-1:0] distance;
      logic [ID_W-1:0]   entry_id;
   } tknl_req_type;

   typedef struct packed {
      logic [ID_W-1:0]   out_entry_id;
      logic [DIST_W-1:0] out_distance;
      logic              valid_res;
      logic              last;
   } tknl_rsp_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [ID_W-1:0]   entry_id;
   } tknl_entry_type;

   // command broadcast to every cell of the row
   typedef struct packed {
      logic insert;   // place the new entry, shifting farther entries right
      logic grow;     // list length grows by one on this insert
      logic pop;      // shift the row left by one during a drain
   } tknl_cmd_type;

endpackage : tknl_pkg
`default_nettype wire

// ----- design/tknl_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tknl_cell
// One slot of the sorted row: holds an entry and its occupancy, compares it
// with the broadcast candidate and trades entries with its neighbors.
// ----------------------------------------------------------------------------
module tknl_cell
   import tknl_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire tknl_cmd_type   cmd,
   input  wire tknl_entry_type new_entry,
   input  wire tknl_entry_type left_entry,
   input  wire logic           left_valid,
   input  wire logic           left_after,
   input  wire tknl_entry_type right_entry,
   input  wire logic           right_valid,
   output tknl_entry_type      held_entry,
   output logic                held_valid,
   output logic                after
);

   tknl_entry_type entry_ff, entry_in;
   logic           valid_ff, valid_in;

   // candidate goes in front of this slot when the slot is empty or farther
   assign after = !valid_ff || (entry_ff.distance > new_entry.distance);

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (cmd.insert) begin
         if (after) begin
            entry_in = left_after ? left_entry : new_entry;
         end
         if (cmd.grow) begin
            valid_in = left_valid;
         end
      end else if (cmd.pop) begin
         entry_in = right_entry;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign held_entry = entry_ff;
   assign held_valid = valid_ff;

endmodule : tknl_cell
`default_nettype wire

// ----- design/top_k_nearest_list.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Insert: one word per cycle while idle, written into the cell row at the accepting edge.
// Drain: the output register takes one held entry per cycle from the head cell, except
//   while the output stalls; accepting the drain word enters the drain state, and ready
//   stays low until the last word of the drain is loaded into the output register.
// Reset clears the occupancy bits, count, drain state and output valid, and sets
//   keep_limit to 16; entry storage is not cleared.
// ----------------------------------------------------------------------------
// top_k_nearest_list
// Sorted list of the nearest candidate entries, built as a row of cells.
// ----------------------------------------------------------------------------
module top_k_nearest_list
   import tknl_pkg::*;
#(
   parameter int MAX_KEEP = MAX_KEEP_DEFAULT
)(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire tknl_req_type       req_word,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output tknl_rsp_type            rsp_word,
   input  wire logic               csr_write_enable,
   input  wire logic [LIMIT_W-1:0] csr_write_data
);

   localparam int CNT_W = $clog2(MAX_KEEP + 1);
   localparam int CMP_W = ((CNT_W > LIMIT_W) ? CNT_W : LIMIT_W) + 1;

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic               state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [LIMIT_W-1:0] keep_limit_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   tknl_rsp_type       rsp_word_ff, rsp_word_in;

   tknl_cmd_type       cmd;
   tknl_entry_type     new_entry;
   tknl_entry_type     cell_entry [MAX_KEEP];
   logic               cell_valid [MAX_KEEP];
   logic               cell_after [MAX_KEEP];
   tknl_entry_type     left_entry [MAX_KEEP];
   logic               left_valid [MAX_KEEP];
   logic               left_after [MAX_KEEP];
   tknl_entry_type     right_entry[MAX_KEEP];
   logic               right_valid[MAX_KEEP];

   logic [CMP_W-1:0]   limit_wide;
   logic [CMP_W-1:0]   limit_eff;
   logic [CMP_W-1:0]   count_next_wide;
   logic               req_take;
   logic               out_free;
   logic               pop_now;

   assign limit_wide      = CMP_W'(keep_limit_ff);
   assign limit_eff       = (limit_wide > CMP_W'(MAX_KEEP)) ? CMP_W'(MAX_KEEP) : limit_wide;
   assign count_next_wide = CMP_W'(count_ff) + CMP_W'(1);

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop_now   = (state_ff == ST_DRAIN) && out_free;

   assign new_entry.distance = req_word.distance;
   assign new_entry.entry_id = req_word.entry_id;

   // a zero limit leaves the list untouched
   assign cmd.insert = req_take && (req_word.operation == OP_INSERT) && (limit_eff != '0);
   assign cmd.grow   = count_next_wide <= limit_eff;
   assign cmd.pop    = pop_now && cell_valid[0];

   genvar gi;
   generate
      for (gi = 0; gi < MAX_KEEP; gi++) begin : g_cell
         if (gi == 0) begin : g_head
            assign left_entry[gi] = '0;
            assign left_valid[gi] = 1'b1;
            assign left_after[gi] = 1'b0;
         end else begin : g_body
            assign left_entry[gi] = cell_entry[gi-1];
            assign left_valid[gi] = cell_valid[gi-1];
            assign left_after[gi] = cell_after[gi-1];
         end
         if (gi == MAX_KEEP - 1) begin : g_tail
            assign right_entry[gi] = '0;
            assign right_valid[gi] = 1'b0;
         end else begin : g_inner
            assign right_entry[gi] = cell_entry[gi+1];
            assign right_valid[gi] = cell_valid[gi+1];
         end

         tknl_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .cmd         (cmd),
            .new_entry   (new_entry),
            .left_entry  (left_entry[gi]),
            .left_valid  (left_valid[gi]),
            .left_after  (left_after[gi]),
            .right_entry (right_entry[gi]),
            .right_valid (right_valid[gi]),
            .held_entry  (cell_entry[gi]),
            .held_valid  (cell_valid[gi]),
            .after       (cell_after[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_word.operation == OP_DRAIN)) begin
               state_in = ST_DRAIN;
            end else if (cmd.insert && cmd.grow) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               // empty list gives a single word marked invalid
               if (cell_valid[0]) begin
                  rsp_word_in.out_entry_id = cell_entry[0].entry_id;
                  rsp_word_in.out_distance = cell_entry[0].distance;
                  rsp_word_in.valid_res    = 1'b1;
                  rsp_word_in.last         = !right_valid[0];
               end else begin
                  rsp_word_in.out_entry_id = '0;
                  rsp_word_in.out_distance = '0;
                  rsp_word_in.valid_res    = 1'b0;
                  rsp_word_in.last         = 1'b1;
               end
               if (!cell_valid[0] || !right_valid[0]) begin
                  state_in = ST_IDLE;
                  count_in = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         keep_limit_ff <= KEEP_LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            keep_limit_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule : top_k_nearest_list
`default_nettype wire
